@@ rtl/mono_lcd_frame_store_refresh_macros.svh @@
// Assertion macros for the frame store refresh controller.
// Used by the top level; expects clk and rst_n in the including scope.
`ifndef MONO_LCD_FRAME_STORE_REFRESH_MACROS_SVH
`define MONO_LCD_FRAME_STORE_REFRESH_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define MLFS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define MLFS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/mlfs_pkg.sv @@
// Package for the monochrome LCD frame store refresh controller.
// Holds payload structs, operation codes and default panel geometry; no dependencies.
`timescale 1ns / 1ps

package mlfs_pkg;

    localparam int ROWS_DEF = 20;
    localparam int COLS_DEF = 240;

    typedef enum logic [1:0] {
        OP_REFRESH   = 2'd0,
        OP_SET_PIXEL = 2'd1,
        OP_CLR_PIXEL = 2'd2,
        OP_CLR_FRAME = 2'd3
    } op_t;

    typedef struct packed {
        op_t        operation;
        logic [7:0] pixel_x;
        logic [7:0] pixel_y;
    } in_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       line_latch;
        logic       frame_mark;
        logic       ac_polarity;
    } out_t;

endpackage

@@ rtl/mono_lcd_frame_store_refresh.sv @@
// Top level of the monochrome LCD frame store refresh controller.
// Depends on mlfs_pkg and mono_lcd_frame_store_refresh_macros.svh.
`timescale 1ns / 1ps

// The frame store is one byte-wide synchronous RAM of ROWS * ceil(COLS/8) bytes
// (600 at the defaults), MSB of each byte the leftmost pixel. A refresh tick, a
// pixel set or a pixel clear first reads the RAM, then delivers the byte or
// writes back the modified byte. A refresh tick also waits while the previous
// result is still held in the output register. A pixel write outside the panel
// is accepted and dropped without leaving the idle state. A whole-frame clear
// writes one byte per cycle, with input held off until the sweep ends. After
// reset the same clearing pass runs before the first transaction is taken.
module mono_lcd_frame_store_refresh #(
    parameter int ROWS = mlfs_pkg::ROWS_DEF,
    parameter int COLS = mlfs_pkg::COLS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  mlfs_pkg::in_t  in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output mlfs_pkg::out_t out_data
);

`include "mono_lcd_frame_store_refresh_macros.svh"

    localparam int BPR    = (COLS + 7) / 8;
    localparam int DEPTH  = ROWS * BPR;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COL_W  = (BPR > 1) ? $clog2(BPR) : 1;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int PROD_W = 16;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_EXEC  = 3'b010,
        ST_CLEAR = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    mlfs_pkg::in_t        cmd_reg;
    logic [ADDR_W-1:0]    addr_reg;
    logic [ADDR_W-1:0]    clr_addr_reg;
    logic [COL_W-1:0]     col_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [ADDR_W-1:0]    row_base_reg;
    logic                 pol_reg;
    logic                 out_valid_reg;
    mlfs_pkg::out_t       out_reg;

    logic [7:0]           mem [DEPTH];
    logic [7:0]           rd_data_reg;
    logic                 mem_re;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_waddr;
    logic [7:0]           mem_wdata;

    logic                 accept;
    logic                 in_panel;
    logic [PROD_W-1:0]    pix_prod;
    logic [ADDR_W-1:0]    pix_addr;
    logic [ADDR_W-1:0]    rd_addr;
    logic [7:0]           pix_mask;
    logic                 out_free;
    logic                 deliver;
    logic                 col_end;
    logic                 row_end;
    logic                 clr_last;

    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign out_free  = !out_valid_reg || out_ready;

    assign in_panel = ({1'b0, in_data.pixel_x} < 9'(COLS))
                   && ({1'b0, in_data.pixel_y} < 9'(ROWS));
    assign pix_prod = PROD_W'(in_data.pixel_y) * PROD_W'(BPR)
                    + PROD_W'(in_data.pixel_x[7:3]);
    assign pix_addr = pix_prod[ADDR_W-1:0];
    assign pix_mask = 8'h80 >> cmd_reg.pixel_x[2:0];

    assign col_end  = (col_reg == COL_W'(BPR - 1));
    assign row_end  = (row_reg == ROW_W'(ROWS - 1));
    assign clr_last = (clr_addr_reg == ADDR_W'(DEPTH - 1));
    assign deliver  = (state_reg == ST_EXEC)
                   && (cmd_reg.operation == mlfs_pkg::OP_REFRESH) && out_free;

    // Read port: refresh reads the scan position, pixel ops read their byte.
    always_comb
    begin
        mem_re  = 1'b0;
        rd_addr = row_base_reg + ADDR_W'(col_reg);
        if (accept)
        begin
            if (in_data.operation == mlfs_pkg::OP_REFRESH)
            begin
                mem_re = 1'b1;
            end
            else if ((in_data.operation == mlfs_pkg::OP_SET_PIXEL
                      || in_data.operation == mlfs_pkg::OP_CLR_PIXEL) && in_panel)
            begin
                mem_re  = 1'b1;
                rd_addr = pix_addr;
            end
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = rd_data_reg;
        case (state_reg)
            ST_EXEC:
            begin
                case (cmd_reg.operation)
                    mlfs_pkg::OP_SET_PIXEL:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = rd_data_reg | pix_mask;
                    end
                    mlfs_pkg::OP_CLR_PIXEL:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = rd_data_reg & ~pix_mask;
                    end
                    default:
                    begin
                        mem_we = 1'b0;
                    end
                endcase
            end
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = 8'h00;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                // Out-of-panel pixel writes are dropped right here.
                if (accept && (in_data.operation == mlfs_pkg::OP_REFRESH || in_panel
                               || in_data.operation == mlfs_pkg::OP_CLR_FRAME))
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (cmd_reg.operation == mlfs_pkg::OP_CLR_FRAME)
                begin
                    state_next = ST_CLEAR;
                end
                else if (cmd_reg.operation != mlfs_pkg::OP_REFRESH || out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                if (clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            row_base_reg  <= '0;
            pol_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (state_reg == ST_CLEAR)
            begin
                clr_addr_reg <= clr_last ? '0 : clr_addr_reg + 1'b1;
            end

            if (deliver)
            begin
                out_valid_reg <= 1'b1;
                if (col_end)
                begin
                    col_reg <= '0;
                    if (row_end)
                    begin
                        row_reg      <= '0;
                        row_base_reg <= '0;
                        pol_reg      <= ~pol_reg;
                    end
                    else
                    begin
                        row_reg      <= row_reg + 1'b1;
                        row_base_reg <= row_base_reg + ADDR_W'(BPR);
                    end
                end
                else
                begin
                    col_reg <= col_reg + 1'b1;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= in_data;
            addr_reg <= pix_addr;
        end
        if (deliver)
        begin
            out_reg.data_byte   <= rd_data_reg;
            out_reg.line_latch  <= col_end;
            out_reg.frame_mark  <= col_end && row_end;
            out_reg.ac_polarity <= pol_reg ^ (col_end && row_end);
        end
    end

    `MLFS_ASSERT_NOW(a_frame_ends_line, out_valid_reg && out_reg.frame_mark, out_reg.line_latch, "frame mark without line latch")
    `MLFS_ASSERT_NOW(a_no_write_on_refresh, (state_reg == ST_EXEC) && (cmd_reg.operation == mlfs_pkg::OP_REFRESH), !mem_we, "store written during refresh")
    `MLFS_ASSERT_NEXT(a_clear_starts, (state_reg == ST_EXEC) && (cmd_reg.operation == mlfs_pkg::OP_CLR_FRAME), (state_reg == ST_CLEAR) && (clr_addr_reg == '0), "frame clear did not start sweep")
    `MLFS_ASSERT_NOW(a_pol_with_frame, pol_reg != $past(pol_reg), out_valid_reg && out_reg.frame_mark && (out_reg.ac_polarity == pol_reg), "polarity toggled without frame mark")

endmodule

@@ test/tb_mono_lcd_frame_store_refresh.sv @@
// Testbench for mono_lcd_frame_store_refresh: directed table, then random operations.
// Checks scanned bytes against a local frame-store predictor. Depends on mlfs_pkg.
`timescale 1ns / 1ps

module tb_mono_lcd_frame_store_refresh;

    localparam int ROWS            = mlfs_pkg::ROWS_DEF;
    localparam int COLS            = mlfs_pkg::COLS_DEF;
    localparam int ROW_BYTES       = (COLS + 7) / 8;
    localparam int STORE_BYTES     = ROWS * ROW_BYTES;
    localparam int RANDOM_ITEMS    = 640;
    localparam int STALL_LIMIT     = 4000;
    localparam int DRAIN_CYCLES    = 20;
    localparam int HOLD_OFF_CYCLES = 80;

    typedef struct {
        mlfs_pkg::in_t  item;
        bit             typed;
        mlfs_pkg::out_t want;
    } script_row_t;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    mlfs_pkg::in_t  in_data;
    logic           out_valid;
    logic           out_ready;
    mlfs_pkg::out_t out_data;

    mono_lcd_frame_store_refresh #(
        .ROWS (ROWS),
        .COLS (COLS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // Local copy of the panel memory and scan position
    logic [7:0]  shadow_store [STORE_BYTES];
    int unsigned shadow_col = 0;
    int unsigned shadow_row = 0;
    logic        shadow_pol = 1'b0;

    mlfs_pkg::out_t expected_bytes [$];
    script_row_t    script [$];

    int errors           = 0;
    int ticks_sent       = 0;
    int writes_sent      = 0;
    int clears_sent      = 0;
    int frames_predicted = 0;
    int bytes_checked    = 0;
    int idle_cycles      = 0;
    int send_run         = 0;
    int recv_run         = 0;

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Returns 1 and the scanned byte for a refresh tick; updates the local store otherwise.
    function automatic bit scan_predict(mlfs_pkg::in_t item, output mlfs_pkg::out_t res);
        int unsigned idx;
        logic [7:0]  mask;
        res = '0;
        case (item.operation)
            mlfs_pkg::OP_SET_PIXEL, mlfs_pkg::OP_CLR_PIXEL:
            begin
                if (item.pixel_x < COLS && item.pixel_y < ROWS)
                begin
                    idx  = item.pixel_y * ROW_BYTES + (item.pixel_x >> 3);
                    mask = 8'h80 >> item.pixel_x[2:0];
                    if (item.operation == mlfs_pkg::OP_SET_PIXEL)
                        shadow_store[idx] = shadow_store[idx] | mask;
                    else
                        shadow_store[idx] = shadow_store[idx] & ~mask;
                end
                return 1'b0;
            end
            mlfs_pkg::OP_CLR_FRAME:
            begin
                foreach (shadow_store[i])
                    shadow_store[i] = 8'h00;
                return 1'b0;
            end
            default: ;
        endcase
        res.data_byte = shadow_store[shadow_row * ROW_BYTES + shadow_col];
        shadow_col++;
        if (shadow_col >= ROW_BYTES)
        begin
            shadow_col = 0;
            res.line_latch = 1'b1;
            shadow_row++;
            if (shadow_row >= ROWS)
            begin
                shadow_row = 0;
                res.frame_mark = 1'b1;
                shadow_pol = ~shadow_pol;
            end
        end
        res.ac_polarity = shadow_pol;
        return 1'b1;
    endfunction

    // Random wait before the next transaction, with occasional runs of back-to-back transactions.
    function automatic int draw_gap(inout int run_left);
        if (run_left > 0)
        begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            run_left = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 7);
    endfunction

    function automatic void add_row(mlfs_pkg::op_t op, int x, int y, bit typed = 1'b0,
                                    mlfs_pkg::out_t want = '0);
        script_row_t row;
        row.item.operation = op;
        row.item.pixel_x   = 8'(x);
        row.item.pixel_y   = 8'(y);
        row.typed          = typed;
        row.want           = want;
        script.push_back(row);
    endfunction

    function automatic mlfs_pkg::in_t random_item();
        mlfs_pkg::in_t item;
        int unsigned   pick;
        pick         = $urandom_range(0, 99);
        item.pixel_x = 8'($urandom_range(0, 255));
        item.pixel_y = 8'($urandom_range(0, 255));
        if (pick < 96)
            item.operation = mlfs_pkg::OP_REFRESH;
        else if (pick < 99)
        begin
            item.operation = (pick < 98) ? mlfs_pkg::OP_SET_PIXEL : mlfs_pkg::OP_CLR_PIXEL;
            if ($urandom_range(0, 4) != 0)
            begin
                // mostly the row under scan, so the write is read back soon
                item.pixel_y = ($urandom_range(0, 2) == 0) ? 8'($urandom_range(0, ROWS - 1))
                                                            : 8'(shadow_row);
                item.pixel_x = 8'($urandom_range(0, COLS - 1));
            end
        end
        else
            item.operation = mlfs_pkg::OP_CLR_FRAME;
        return item;
    endfunction

    task automatic send_item(mlfs_pkg::in_t item, bit typed, mlfs_pkg::out_t want);
        int             gap;
        mlfs_pkg::out_t res;
        gap = draw_gap(send_run);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (scan_predict(item, res))
        begin
            ticks_sent++;
            if (res.frame_mark)
                frames_predicted++;
            expected_bytes.push_back(typed ? want : res);
        end
        else if (item.operation == mlfs_pkg::OP_CLR_FRAME)
            clears_sent++;
        else
            writes_sent++;
    endtask

    // Stimulus
    initial
    begin
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        in_data  <= '0;
        foreach (shadow_store[i])
            shadow_store[i] = 8'h00;

        add_row(mlfs_pkg::OP_REFRESH,     0,   0, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0});
        add_row(mlfs_pkg::OP_SET_PIXEL,   8,   0);
        add_row(mlfs_pkg::OP_SET_PIXEL,  15,   0);
        add_row(mlfs_pkg::OP_SET_PIXEL,   9,   0);
        add_row(mlfs_pkg::OP_CLR_PIXEL,   9,   0);
        add_row(mlfs_pkg::OP_REFRESH,     0,   0, 1'b1, '{8'h81, 1'b0, 1'b0, 1'b0});
        add_row(mlfs_pkg::OP_SET_PIXEL,  16,   0);
        add_row(mlfs_pkg::OP_SET_PIXEL,  17,   0);
        add_row(mlfs_pkg::OP_SET_PIXEL,  23,   0);
        // off-panel writes are dropped
        add_row(mlfs_pkg::OP_SET_PIXEL, 240,   0);
        add_row(mlfs_pkg::OP_SET_PIXEL,   0,  20);
        add_row(mlfs_pkg::OP_SET_PIXEL, 255, 255);
        add_row(mlfs_pkg::OP_CLR_PIXEL, 255, 255);
        add_row(mlfs_pkg::OP_CLR_PIXEL,   0,   0);
        add_row(mlfs_pkg::OP_REFRESH,   255, 255, 1'b1, '{8'hC1, 1'b0, 1'b0, 1'b0});
        add_row(mlfs_pkg::OP_SET_PIXEL,  24,   0);
        add_row(mlfs_pkg::OP_SET_PIXEL,  31,   0);
        add_row(mlfs_pkg::OP_CLR_FRAME,   0,   0);
        add_row(mlfs_pkg::OP_REFRESH,     0,   0, 1'b1, '{8'h00, 1'b0, 1'b0, 1'b0});
        add_row(mlfs_pkg::OP_SET_PIXEL,  32,   0);
        add_row(mlfs_pkg::OP_SET_PIXEL, 239,  19);
        add_row(mlfs_pkg::OP_SET_PIXEL, 232,   0);
        add_row(mlfs_pkg::OP_REFRESH,     0,   0);

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
            send_item(script[i].item, script[i].typed, script[i].want);
        // refresh-heavy mix so the scan normally wraps a full frame
        for (int n = 0; n < RANDOM_ITEMS; n++)
            send_item(random_item(), 1'b0, '0);
        in_valid <= 1'b0;

        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d refresh ticks across %0d frame wrap(s), %0d pixel writes",
                 ticks_sent, frames_predicted, writes_sent);
        $display("and %0d frame clears; %0d scanned bytes checked.", clears_sent, bytes_checked);
        if (errors == 0)
            $display("** mono_lcd_frame_store_refresh: PASSED **");
        else
            $display("** mono_lcd_frame_store_refresh: FAILED **");
        $finish;
    end

    // Result side
    initial
    begin
        mlfs_pkg::out_t want;
        int             gap;
        out_ready <= 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            if (bytes_checked == 150 || bytes_checked == 450)
            begin
                // long hold-off: output register fills and the block stalls its input
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            gap = draw_gap(recv_run);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            bytes_checked++;
            if (expected_bytes.size() == 0)
            begin
                $error("unexpected transaction on output: %h", out_data);
                errors++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_data.data_byte !== want.data_byte)
                begin
                    $error("data_byte: expected %h, got %h", want.data_byte, out_data.data_byte);
                    errors++;
                end
                if (out_data.line_latch !== want.line_latch)
                begin
                    $error("line_latch: expected %b, got %b", want.line_latch,
                           out_data.line_latch);
                    errors++;
                end
                if (out_data.frame_mark !== want.frame_mark)
                begin
                    $error("frame_mark: expected %b, got %b", want.frame_mark,
                           out_data.frame_mark);
                    errors++;
                end
                if (out_data.ac_polarity !== want.ac_polarity)
                begin
                    $error("ac_polarity: expected %b, got %b", want.ac_polarity,
                           out_data.ac_polarity);
                    errors++;
                end
            end
        end
    end

    // Watchdog: cycles without any transaction on either side
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("** mono_lcd_frame_store_refresh: FAILED **");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

endmodule
